@@ rtl/core/rthc_pkg.sv @@
// ----------------------------------------------------------------------------
// rthc_pkg
// Widths, pipeline split and stage payload for the RGB to HSV converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rthc_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int HUE_BITS     = 16;

  // Number of divider stages behind the front stage
  localparam int DIV_STAGES   = 4;

  // Hue divider: num * 2^HUE_QW / (6d), remainder always below 6d
  localparam int HUE_STEP     = (HUE_BITS + DIV_STAGES - 1) / DIV_STAGES;
  localparam int HUE_QW       = HUE_STEP * DIV_STAGES;
  localparam int HUE_DW       = CHANNEL_BITS + 3;
  localparam int HUE_RW       = HUE_DW + 1;
  localparam int HUE_TRIM     = HUE_QW - HUE_BITS;

  // Saturation divider: d * (2^CHANNEL_BITS - 1) / max
  localparam int SAT_STEP     = (CHANNEL_BITS + DIV_STAGES - 1) / DIV_STAGES;
  localparam int SAT_QW       = SAT_STEP * DIV_STAGES;
  localparam int SAT_RW       = CHANNEL_BITS + 1;
  localparam int SAT_TRIM     = SAT_QW - CHANNEL_BITS;
  localparam int DM_W         = 2 * CHANNEL_BITS;
  localparam int SAT_EW       = CHANNEL_BITS + SAT_QW;

  typedef struct packed {
    logic [HUE_RW-1:0]       hue_rem;
    logic [HUE_DW-1:0]       hue_div;
    logic [HUE_QW-1:0]       hue_quo;
    logic [SAT_RW-1:0]       sat_rem;
    logic [SAT_QW-1:0]       sat_low;
    logic [CHANNEL_BITS-1:0] sat_div;
    logic [SAT_QW-1:0]       sat_quo;
    logic                    grey;
    logic [CHANNEL_BITS-1:0] brightness;
    logic [CHANNEL_BITS-1:0] opacity;
  } stage_t;

endpackage

`default_nettype wire

@@ rtl/core/rthc_if.sv @@
// ----------------------------------------------------------------------------
// rthc_if
// Valid/ready channels for RGBA pixels in and HSVA pixels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rthc_pix_if;
  import rthc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;
  logic [CHANNEL_BITS-1:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

interface rthc_hsv_if;
  import rthc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [HUE_BITS-1:0]     hue;
  logic [CHANNEL_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0] brightness;
  logic [CHANNEL_BITS-1:0] opacity;

  modport source (output valid, output hue, output saturation, output brightness,
                  output opacity, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  input opacity, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rthc_front.sv @@
// ----------------------------------------------------------------------------
// rthc_front
// First stage: max/min, hue sector numerator and divider setup.
// ----------------------------------------------------------------------------
`default_nettype none

module rthc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  rthc_pix_if.sink             pix_i,
  output logic                 vld_o,
  output rthc_pkg::stage_t     dat_o,
  input  wire logic            rdy_i
);
  import rthc_pkg::*;

  logic   vld_q;
  stage_t dat_q;
  stage_t dat_d;
  logic   rdy;

  logic [CHANNEL_BITS-1:0] mx, mn, d;
  logic [HUE_DW-1:0]       d_x, num;
  logic [DM_W-1:0]         dm;
  logic [SAT_EW-1:0]       ext;

  always_comb begin
    mx = pix_i.red;
    if (pix_i.green > mx) mx = pix_i.green;
    if (pix_i.blue > mx)  mx = pix_i.blue;
    mn = pix_i.red;
    if (pix_i.green < mn) mn = pix_i.green;
    if (pix_i.blue < mn)  mn = pix_i.blue;
    d   = mx - mn;
    d_x = HUE_DW'(d);

    // Red wins ties, then green; wrap the red sector into [0, 6d)
    if (mx == pix_i.red) begin
      if (pix_i.green >= pix_i.blue) begin
        num = HUE_DW'(pix_i.green - pix_i.blue);
      end else begin
        num = (d_x << 2) + (d_x << 1) - HUE_DW'(pix_i.blue - pix_i.green);
      end
    end else if (mx == pix_i.green) begin
      num = (d_x << 1) + HUE_DW'(pix_i.blue) - HUE_DW'(pix_i.red);
    end else begin
      num = (d_x << 2) + HUE_DW'(pix_i.red) - HUE_DW'(pix_i.green);
    end

    dm  = (DM_W'(d) << CHANNEL_BITS) - DM_W'(d);
    ext = SAT_EW'(dm) << SAT_TRIM;

    dat_d            = '0;
    dat_d.hue_rem    = HUE_RW'(num);
    dat_d.hue_div    = (d_x << 2) + (d_x << 1);
    dat_d.hue_quo    = '0;
    dat_d.sat_rem    = SAT_RW'(ext[SAT_EW-1 -: CHANNEL_BITS]);
    dat_d.sat_low    = ext[SAT_QW-1:0];
    dat_d.sat_div    = mx;
    dat_d.sat_quo    = '0;
    dat_d.grey       = (d == '0);
    dat_d.brightness = mx;
    dat_d.opacity    = pix_i.alpha;
  end

  assign rdy         = !vld_q || rdy_i;
  assign pix_i.ready = rdy;
  assign vld_o       = vld_q;
  assign dat_o       = dat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy) begin
      vld_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && pix_i.valid) begin
      dat_q <= dat_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rthc_div_stage.sv @@
// ----------------------------------------------------------------------------
// rthc_div_stage
// One pipeline slice of the hue and saturation restoring dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module rthc_div_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              vld_i,
  input  wire rthc_pkg::stage_t  dat_i,
  output logic                   rdy_o,
  output logic                   vld_o,
  output rthc_pkg::stage_t       dat_o,
  input  wire logic              rdy_i
);
  import rthc_pkg::*;

  logic              vld_q;
  stage_t            dat_q;
  stage_t            dat_d;
  logic [HUE_RW-1:0] hr;
  logic [SAT_RW-1:0] sr;

  always_comb begin
    dat_d = dat_i;
    hr    = '0;
    sr    = '0;
    for (int i = 0; i < HUE_STEP; i++) begin
      hr = {dat_d.hue_rem[HUE_RW-2:0], 1'b0};
      if (hr >= HUE_RW'(dat_d.hue_div)) begin
        dat_d.hue_rem = hr - HUE_RW'(dat_d.hue_div);
        dat_d.hue_quo = {dat_d.hue_quo[HUE_QW-2:0], 1'b1};
      end else begin
        dat_d.hue_rem = hr;
        dat_d.hue_quo = {dat_d.hue_quo[HUE_QW-2:0], 1'b0};
      end
    end
    for (int j = 0; j < SAT_STEP; j++) begin
      // shift in the next dividend bit
      sr            = {dat_d.sat_rem[SAT_RW-2:0], dat_d.sat_low[SAT_QW-1]};
      dat_d.sat_low = dat_d.sat_low << 1;
      if (sr >= SAT_RW'(dat_d.sat_div)) begin
        dat_d.sat_rem = sr - SAT_RW'(dat_d.sat_div);
        dat_d.sat_quo = {dat_d.sat_quo[SAT_QW-2:0], 1'b1};
      end else begin
        dat_d.sat_rem = sr;
        dat_d.sat_quo = {dat_d.sat_quo[SAT_QW-2:0], 1'b0};
      end
    end
  end

  assign rdy_o = !vld_q || rdy_i;
  assign vld_o = vld_q;
  assign dat_o = dat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      dat_q <= dat_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rgb_to_hsv_convert_top.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_top
// RGBA to HSVA pixel converter, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i  carries one RGBA pixel per item (valid/ready).
//   hsv_o  carries hue (fraction of a turn), saturation, brightness (max
//          channel) and opacity (alpha copy), one item per input item, in order.
//   The pipeline has 5 register stages: one front stage (max/min and hue
//   numerator) and four divider stages, each doing a quarter of the hue and
//   saturation quotient bits. hsv_o.valid and the result come from the last
//   divider stage's register.
//   Throughput is one pixel per cycle while hsv_o is not stalled.
//   Reset clears all stage valid bits; the block then accepts pixels at once.
//   When hsv_o stalls, each stage holds its item and ready ripples back, so
//   a stage only takes a new item when its own slot frees up. No item is
//   lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_convert_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rthc_pix_if.sink   pix_i,
  rthc_hsv_if.source hsv_o
);
  import rthc_pkg::*;

  logic   vld [DIV_STAGES+1];
  logic   rdy [1:DIV_STAGES+1];
  stage_t dat [DIV_STAGES+1];

  rthc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_i),
    .vld_o  (vld[0]),
    .dat_o  (dat[0]),
    .rdy_i  (rdy[1])
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    rthc_div_stage u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[k]),
      .dat_i  (dat[k]),
      .rdy_o  (rdy[k+1]),
      .vld_o  (vld[k+1]),
      .dat_o  (dat[k+1]),
      .rdy_i  (rdy[k+2])
    );
  end

  // last stage advances on the receiver's ready
  assign rdy[DIV_STAGES+1] = hsv_o.ready;

  // Drop the extra low quotient bits; zero out the undefined divide cases
  assign hsv_o.valid      = vld[DIV_STAGES];
  assign hsv_o.hue        = dat[DIV_STAGES].grey ? '0 :
                            HUE_BITS'(dat[DIV_STAGES].hue_quo >> HUE_TRIM);
  assign hsv_o.saturation = (dat[DIV_STAGES].brightness == '0) ? '0 :
                            CHANNEL_BITS'(dat[DIV_STAGES].sat_quo >> SAT_TRIM);
  assign hsv_o.brightness = dat[DIV_STAGES].brightness;
  assign hsv_o.opacity    = dat[DIV_STAGES].opacity;

endmodule

`default_nettype wire

@@ rtl/core/rthc_checker.sv @@
// ----------------------------------------------------------------------------
// rthc_checker
// Port-level checks on the converter output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rthc_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              hsv_valid_i,
  input wire logic                              hsv_ready_i,
  input wire logic [rthc_pkg::HUE_BITS-1:0]     hue_i,
  input wire logic [rthc_pkg::CHANNEL_BITS-1:0] saturation_i,
  input wire logic [rthc_pkg::CHANNEL_BITS-1:0] brightness_i,
  input wire logic [rthc_pkg::CHANNEL_BITS-1:0] opacity_i
);
  import rthc_pkg::*;

  // zero saturation only happens for grey pixels, which have no hue
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_valid_i && (saturation_i == '0) |-> (hue_i == '0))
    else $error("nonzero hue on a zero-saturation item");

  a_black_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_valid_i && (brightness_i == '0) |-> (saturation_i == '0))
    else $error("nonzero saturation on a black item");

  a_full_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_valid_i && (saturation_i == '1) |-> (brightness_i != '0))
    else $error("full saturation on a black item");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_valid_i && !hsv_ready_i |=> hsv_valid_i && $stable(hue_i) &&
      $stable(saturation_i) && $stable(brightness_i) && $stable(opacity_i))
    else $error("stalled output item changed");

endmodule

bind rgb_to_hsv_convert_top rthc_checker u_rthc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .hsv_valid_i  (hsv_o.valid),
  .hsv_ready_i  (hsv_o.ready),
  .hue_i        (hsv_o.hue),
  .saturation_i (hsv_o.saturation),
  .brightness_i (hsv_o.brightness),
  .opacity_i    (hsv_o.opacity)
);

`default_nettype wire

@@ sim/rgb_to_hsv_convert_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_top_tb
// Drives RGBA pixels into the converter through a directed table of corner
// pixels, then random pixels under several idle and backpressure patterns.
// Every HSVA result is compared in order against a typed-in value from the
// table or a local integer model of the conversion.
// ----------------------------------------------------------------------------

module rgb_to_hsv_convert_top_tb;
  import rthc_pkg::*;

  localparam int CB         = CHANNEL_BITS;
  localparam int CH_FULL    = (1 << CB) - 1;
  localparam int LATENCY    = 5;
  localparam int CYCLE_CAP  = 200000;
  localparam int NUM_ROWS   = 20;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
    logic [CB-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    logic [CB-1:0]       sat;
    logic [CB-1:0]       val;
    logic [CB-1:0]       opa;
  } hsv_t;

  typedef struct packed {
    pixel_t px;
    logic   known;
    hsv_t   want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_n;

  rthc_pix_if pix ();
  rthc_hsv_if hsv ();

  rgb_to_hsv_convert_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .pix_i  (pix),
    .hsv_o  (hsv)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  hsv_t   hsv_pending [$];
  int     mismatches  = 0;
  int     cycle_count = 0;
  int     idle_pct    = 0;
  int     stall_pct   = 0;
  row_t   rows [NUM_ROWS];

  // Integer HSV conversion: hue as a fraction of a turn, red wins ties
  function automatic hsv_t rgb_to_hsv(pixel_t px);
    logic [31:0] r, g, b, mx, mn, d, num;
    hsv_t        res;
    r  = 32'(px.red);
    g  = 32'(px.green);
    b  = 32'(px.blue);
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d   = mx - mn;
    res = '0;
    if (d != 0) begin
      if (mx == r) begin
        num = (g >= b) ? g - b : 6 * d - (b - g);
      end else if (mx == g) begin
        num = 2 * d + b - r;
      end else begin
        num = 4 * d + r - g;
      end
      res.hue = HUE_BITS'((num << HUE_BITS) / (6 * d));
    end
    if (mx != 0) res.sat = CB'((d * CH_FULL) / mx);
    res.val = CB'(mx);
    res.opa = px.alpha;
    return res;
  endfunction

  // Mostly uniform pixels, with greys, ties and near-extreme channels mixed in
  function automatic pixel_t random_pixel();
    pixel_t px;
    int     kind;
    kind = $urandom_range(7);
    px   = pixel_t'($urandom);
    case (kind)
      0: begin
        px.green = px.red;
        px.blue  = px.red;
      end
      1: begin
        case ($urandom_range(2))
          0: px.green = px.red;
          1: px.blue  = px.red;
          default: px.blue = px.green;
        endcase
      end
      2: begin
        px.red   = ($urandom_range(1) != 0) ? CB'(CH_FULL - $urandom_range(1)) :
                                              CB'($urandom_range(1));
        px.green = ($urandom_range(1) != 0) ? CB'(CH_FULL - $urandom_range(1)) :
                                              CB'($urandom_range(1));
        px.blue  = ($urandom_range(1) != 0) ? CB'(CH_FULL - $urandom_range(1)) :
                                              CB'($urandom_range(1));
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic send_pixel(input pixel_t px, input hsv_t want);
    while ($urandom_range(99) < idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.red   <= px.red;
    pix.green <= px.green;
    pix.blue  <= px.blue;
    pix.alpha <= px.alpha;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    hsv_pending.push_back(want);
  endtask

  task automatic wait_for_drain();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (hsv_pending.size() != 0) @(posedge clk_i);
  endtask

  // Receiver backpressure
  always @(posedge clk_i) begin
    hsv.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    hsv_t seen;
    hsv_t want;
    if (rst_n && hsv.valid && hsv.ready) begin
      seen = '{hsv.hue, hsv.saturation, hsv.brightness, hsv.opacity};
      if (hsv_pending.size() == 0) begin
        $display("%0t: unexpected item hue=%0d sat=%0d val=%0d opa=%0d",
                 $time, seen.hue, seen.sat, seen.val, seen.opa);
        mismatches++;
      end else begin
        want = hsv_pending.pop_front();
        if (seen !== want) begin
          $display({"%0t: expected hue=%0d sat=%0d val=%0d opa=%0d, ",
                    "got hue=%0d sat=%0d val=%0d opa=%0d"},
                   $time, want.hue, want.sat, want.val, want.opa,
                   seen.hue, seen.sat, seen.val, seen.opa);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int idle_plan  [5];
    int stall_plan [5];
    int count_plan [5];
    pixel_t px;

    rst_n          <= 1'b0;
    pix.valid      <= 1'b0;
    pix.red        <= '0;
    pix.green      <= '0;
    pix.blue       <= '0;
    pix.alpha      <= '0;

    // Known results are typed in only where they follow at a glance
    rows = '{
      '{'{8'd0,   8'd0,   8'd0,   8'd0},   1'b1, '{16'd0,     8'd0,   8'd0,   8'd0}},
      '{'{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, '{16'd0,     8'd0,   8'd255, 8'd255}},
      '{'{8'd128, 8'd128, 8'd128, 8'd170}, 1'b1, '{16'd0,     8'd0,   8'd128, 8'd170}},
      '{'{8'd255, 8'd0,   8'd0,   8'd255}, 1'b1, '{16'd0,     8'd255, 8'd255, 8'd255}},
      '{'{8'd0,   8'd255, 8'd0,   8'd0},   1'b1, '{16'd21845, 8'd255, 8'd255, 8'd0}},
      '{'{8'd0,   8'd0,   8'd255, 8'd85},  1'b1, '{16'd43690, 8'd255, 8'd255, 8'd85}},
      '{'{8'd1,   8'd0,   8'd0,   8'd1},   1'b1, '{16'd0,     8'd255, 8'd1,   8'd1}},
      '{'{8'd255, 8'd255, 8'd0,   8'd254}, 1'b0, '0},
      '{'{8'd0,   8'd255, 8'd255, 8'd127}, 1'b0, '0},
      '{'{8'd255, 8'd0,   8'd255, 8'd128}, 1'b0, '0},
      '{'{8'd255, 8'd0,   8'd1,   8'd15},  1'b0, '0},
      '{'{8'd255, 8'd1,   8'd0,   8'd240}, 1'b0, '0},
      '{'{8'd10,  8'd200, 8'd90,  8'd51},  1'b0, '0},
      '{'{8'd90,  8'd10,  8'd200, 8'd204}, 1'b0, '0},
      '{'{8'd254, 8'd255, 8'd254, 8'd1},   1'b0, '0},
      '{'{8'd1,   8'd1,   8'd0,   8'd2},   1'b0, '0},
      '{'{8'd0,   8'd1,   8'd1,   8'd253}, 1'b0, '0},
      '{'{8'd0,   8'd0,   8'd1,   8'd64},  1'b0, '0},
      '{'{8'd200, 8'd100, 8'd150, 8'd191}, 1'b0, '0},
      '{'{8'd1,   8'd254, 8'd128, 8'd126}, 1'b0, '0}
    };

    idle_plan  = '{0,   60,  0,   23,  0};
    stall_plan = '{0,   0,   60,  23,  0};
    count_plan = '{250, 250, 250, 250, 230};

    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_pixel(rows[i].px, rows[i].known ? rows[i].want : rgb_to_hsv(rows[i].px));
    end
    // Hold off the sender until the pipeline is empty
    wait_for_drain();

    foreach (count_plan[p]) begin
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      repeat (count_plan[p]) begin
        px = random_pixel();
        send_pixel(px, rgb_to_hsv(px));
      end
      wait_for_drain();
    end

    stall_pct = 0;
    repeat (4 * LATENCY) @(posedge clk_i);
    if (mismatches == 0 && hsv_pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
